// File: src/pidc_pkg.sv
`timescale 1ns / 1ps

package pidc_pkg;

    localparam int DataW   = 16;
    localparam int GainW   = 24;
    localparam int ErrW    = DataW + 1;         // difference of two samples
    localparam int ProdW   = GainW + ErrW + 1;  // gain times difference, one spare bit
    localparam int IntW    = 32;                // integral, Q.16, limited to out*2^15
    localparam int IntSumW = ProdW + 1;         // integral plus increment before clamping
    localparam int PdW     = ProdW + 1;         // proportional minus derivative term
    localparam int AccW    = PdW + 1;           // pd plus integral
    localparam int TW      = AccW + 8;          // sum scaled by 200
    localparam int YW      = TW - 16;           // scaled sum with the fraction dropped
    localparam int LimW    = 25;                // 200 times a 17 bit limit
    localparam int ZW      = 21;                // (y / 8) plus bias, quotient input
    localparam int RecipW  = 22;
    localparam int MulW    = ZW + RecipW;

    localparam int AddrW   = 5;
    localparam int CfgDataW = 32;

    localparam int QDepth  = 16;
    localparam int QPtrW   = $clog2(QDepth);
    localparam int QCntW   = QPtrW + 1;

    // Rounding bias: 100 * 2^16, half of the divisor 200 * 2^16.
    localparam logic signed [TW-1:0] RoundBias = 52'sd6553600;
    // floor(z / 25) = (z * ceil(2^26 / 25)) >> 26, exact for z below 2^21.
    localparam logic [RecipW-1:0] RecipMul   = 22'd2684355;
    localparam int                RecipShift = 26;
    // 25 * 32768, makes the quotient input non-negative in the valid range.
    localparam logic [ZW-1:0]     ZBias      = 21'd819200;

    typedef enum logic [2:0] {
        REG_KP_GAIN       = 3'd0,
        REG_KI_GAIN       = 3'd1,
        REG_KD_GAIN       = 3'd2,
        REG_REVERSE       = 3'd3,
        REG_OUT_MIN       = 3'd4,
        REG_OUT_MAX       = 3'd5,
        REG_SAMPLE_PERIOD = 3'd6,
        REG_AUTO_MODE     = 3'd7
    } reg_idx_t;

    typedef struct packed {
        logic [GainW-1:0]        kp_gain;
        logic [GainW-1:0]        ki_gain;
        logic [GainW-1:0]        kd_gain;
        logic                    reverse_direction;
        logic signed [DataW-1:0] out_min;
        logic signed [DataW-1:0] out_max;
        logic [DataW-1:0]        sample_period;
        logic                    auto_mode;
    } cfg_t;

    typedef struct packed {
        logic signed [DataW-1:0] manual_output;
        logic signed [DataW-1:0] measurement;
        logic signed [DataW-1:0] setpoint;
    } item_t;

    // Products and control from the first stage to the integral stage.
    typedef struct packed {
        logic                    init;
        logic                    fire;
        logic signed [IntW-1:0]  init_val;
        logic signed [ProdW-1:0] p_kp;
        logic signed [ProdW-1:0] p_ki;
        logic signed [ProdW-1:0] p_kdm;
        logic signed [ProdW-1:0] p_kds;
    } front_t;

    // Terms from the integral stage to the output datapath.
    typedef struct packed {
        logic signed [IntW-1:0]  i_new;
        logic signed [PdW-1:0]   pd;
        logic signed [ProdW-1:0] p_kds;
    } mid_t;

    // Clamp to half of the drive limits in Q.16, upper bound tested first.
    function automatic logic signed [IntW-1:0] clamp_integral(
        input logic signed [IntSumW-1:0] x,
        input logic signed [DataW-1:0]   lo,
        input logic signed [DataW-1:0]   hi
    );
        logic signed [IntSumW-1:0] lim_hi;
        logic signed [IntSumW-1:0] lim_lo;
        logic signed [IntW-1:0]    res;
        lim_hi = {{(IntSumW-DataW-15){hi[DataW-1]}}, hi, 15'b0};
        lim_lo = {{(IntSumW-DataW-15){lo[DataW-1]}}, lo, 15'b0};
        if (x > lim_hi) begin
            res = {hi[DataW-1], hi, 15'b0};
        end
        else if (x < lim_lo) begin
            res = {lo[DataW-1], lo, 15'b0};
        end
        else begin
            res = x[IntW-1:0];
        end
        return res;
    endfunction

endpackage

// File: src/pid_controller_clamped_integral.sv
// Channel   Direction  Handshake                  Payload
// s_*       in         s_tvalid / s_tready        s_tdata: setpoint, measurement, manual_output
// m_*       out        m_tvalid / m_tready        m_tdata: drive
// APB       in         psel, penable, pready      paddr, pwdata, prdata (eight registers)
//
// One tick transaction can be accepted every cycle while s_tready is high. A tick that
// runs a controller step delivers its drive through the pipeline of input register,
// products, integral update, sum, scaling, limit compare and select.
// Results wait in a 16-entry queue; s_tready drops only while the queue plus the
// ticks in flight would fill it, so output stalls never lose a result.
// Reset is asynchronous and active low; the tick counter comes out of reset
// saturated, so the first tick in automatic mode runs a step.
`timescale 1ns / 1ps

module pid_controller_clamped_integral (
    input  logic                              clk,
    input  logic                              rst_n,
    // s_tdata: setpoint [15:0], measurement [31:16], manual_output [47:32]
    input  logic                              s_tvalid,
    output logic                              s_tready,
    input  logic [3*pidc_pkg::DataW-1:0]      s_tdata,
    // m_tdata: drive [15:0]
    output logic                              m_tvalid,
    input  logic                              m_tready,
    output logic [pidc_pkg::DataW-1:0]        m_tdata,
    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [pidc_pkg::AddrW-1:0]        paddr,
    input  logic [pidc_pkg::CfgDataW-1:0]     pwdata,
    output logic [pidc_pkg::CfgDataW-1:0]     prdata,
    output logic                              pready
);
    import pidc_pkg::*;

    cfg_t                    cfg;
    logic                    in_valid_reg, in_valid_next;
    item_t                   in_item_reg;
    logic                    accept;

    logic                    a_valid;
    front_t                  a_data;
    logic                    b_valid;
    mid_t                    b_data;
    logic [3:0]              busy;
    logic                    r_valid;
    logic signed [DataW-1:0] r_drive;
    logic [QCntW-1:0]        q_count;
    logic                    q_pop;
    logic [QCntW-1:0]        occupancy;

    pidc_regs u_regs (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    // Input register: the tick enters the datapath in the cycle after acceptance.
    assign accept        = s_tvalid && s_tready;
    assign in_valid_next = accept;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else
        begin
            in_valid_reg <= in_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            in_item_reg <= s_tdata;
        end
    end

    // Sample bookkeeping, mode change handling and the four gain products.
    pidc_front u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid_reg),
        .item     (in_item_reg),
        .cfg      (cfg),
        .a_valid  (a_valid),
        .a_data   (a_data)
    );

    // Integral accumulate with clamping at half the drive limits.
    pidc_integ u_integ (
        .clk     (clk),
        .rst_n   (rst_n),
        .a_valid (a_valid),
        .a_data  (a_data),
        .cfg     (cfg),
        .b_valid (b_valid),
        .b_data  (b_data)
    );

    // Sum, scale by 1/(200*2^16) with rounding, and clamp to the drive limits.
    pidc_output u_output (
        .clk     (clk),
        .rst_n   (rst_n),
        .b_valid (b_valid),
        .b_data  (b_data),
        .cfg     (cfg),
        .busy    (busy),
        .r_valid (r_valid),
        .r_drive (r_drive)
    );

    assign q_pop = m_tvalid && m_tready;

    pidc_fifo u_fifo (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (r_valid),
        .push_data (r_drive),
        .pop       (q_pop),
        .not_empty (m_tvalid),
        .head      (m_tdata),
        .count     (q_count)
    );

    // Every tick in flight is counted as if it will produce a result, so the
    // queue can never overflow regardless of how long the output stalls.
    always_comb
    begin
        occupancy = q_count
                    + {{(QCntW-1){1'b0}}, in_valid_reg}
                    + {{(QCntW-1){1'b0}}, a_valid}
                    + {{(QCntW-1){1'b0}}, b_valid}
                    + {{(QCntW-1){1'b0}}, busy[0]}
                    + {{(QCntW-1){1'b0}}, busy[1]}
                    + {{(QCntW-1){1'b0}}, busy[2]}
                    + {{(QCntW-1){1'b0}}, busy[3]};
    end

    assign s_tready = (occupancy < QCntW'(QDepth));

    // The flow control keeps queued plus in-flight results within the queue.
    a_occupancy: assert property (@(posedge clk) disable iff (!rst_n)
        occupancy <= QCntW'(QDepth))
        else $error("result queue occupancy exceeds its depth");

    // A result only enters the queue when there is room for it.
    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        r_valid |-> (q_count < QCntW'(QDepth)))
        else $error("result pushed into a full queue");

    // A tick in manual mode never starts a controller step.
    a_manual_quiet: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid_reg && !cfg.auto_mode) |=> !a_valid)
        else $error("manual mode tick reached the integral stage");

endmodule

// File: src/pidc_regs.sv
`timescale 1ns / 1ps

module pidc_regs (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [pidc_pkg::AddrW-1:0]        paddr,
    input  logic [pidc_pkg::CfgDataW-1:0]     pwdata,
    output logic [pidc_pkg::CfgDataW-1:0]     prdata,
    output logic                              pready,
    output pidc_pkg::cfg_t                    cfg
);
    import pidc_pkg::*;

    cfg_t     cfg_reg;
    cfg_t     cfg_next;
    reg_idx_t idx;
    logic     wr_en;

    assign idx    = reg_idx_t'(paddr[AddrW-1:2]);
    assign wr_en  = psel && penable && pwrite;
    assign pready = 1'b1;
    assign cfg    = cfg_reg;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (wr_en)
        begin
            case (idx)
                REG_KP_GAIN:       cfg_next.kp_gain           = pwdata[GainW-1:0];
                REG_KI_GAIN:       cfg_next.ki_gain           = pwdata[GainW-1:0];
                REG_KD_GAIN:       cfg_next.kd_gain           = pwdata[GainW-1:0];
                REG_REVERSE:       cfg_next.reverse_direction = pwdata[0];
                REG_OUT_MIN:       cfg_next.out_min           = pwdata[DataW-1:0];
                REG_OUT_MAX:       cfg_next.out_max           = pwdata[DataW-1:0];
                REG_SAMPLE_PERIOD: cfg_next.sample_period     = pwdata[DataW-1:0];
                REG_AUTO_MODE:     cfg_next.auto_mode         = pwdata[0];
                default:           cfg_next = cfg_reg;
            endcase
        end
    end

    always_comb
    begin
        case (idx)
            REG_KP_GAIN:       prdata = {{(CfgDataW-GainW){1'b0}}, cfg_reg.kp_gain};
            REG_KI_GAIN:       prdata = {{(CfgDataW-GainW){1'b0}}, cfg_reg.ki_gain};
            REG_KD_GAIN:       prdata = {{(CfgDataW-GainW){1'b0}}, cfg_reg.kd_gain};
            REG_REVERSE:       prdata = {{(CfgDataW-1){1'b0}}, cfg_reg.reverse_direction};
            REG_OUT_MIN:       prdata = {{(CfgDataW-DataW){1'b0}}, cfg_reg.out_min};
            REG_OUT_MAX:       prdata = {{(CfgDataW-DataW){1'b0}}, cfg_reg.out_max};
            REG_SAMPLE_PERIOD: prdata = {{(CfgDataW-DataW){1'b0}}, cfg_reg.sample_period};
            REG_AUTO_MODE:     prdata = {{(CfgDataW-1){1'b0}}, cfg_reg.auto_mode};
            default:           prdata = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.kp_gain           <= '0;
            cfg_reg.ki_gain           <= '0;
            cfg_reg.kd_gain           <= '0;
            cfg_reg.reverse_direction <= 1'b0;
            cfg_reg.out_min           <= 16'sd0;
            cfg_reg.out_max           <= 16'sd255;
            cfg_reg.sample_period     <= 16'd100;
            cfg_reg.auto_mode         <= 1'b0;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

endmodule

// File: src/pidc_front.sv
`timescale 1ns / 1ps

module pidc_front (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    input  pidc_pkg::item_t   item,
    input  pidc_pkg::cfg_t    cfg,
    output logic              a_valid,
    output pidc_pkg::front_t  a_data
);
    import pidc_pkg::*;

    logic [DataW-1:0]        tick_count_reg, tick_count_next;
    logic                    was_auto_reg, was_auto_next;
    logic signed [DataW-1:0] prev_meas_reg, prev_meas_next;
    logic signed [DataW-1:0] prev_sp_reg, prev_sp_next;
    logic                    a_valid_reg, a_valid_next;
    front_t                  a_data_reg, a_data_next;

    logic [DataW-1:0]        tick_inc;
    logic                    init, fire;
    logic signed [DataW-1:0] prev_m, prev_s, cm;
    logic signed [ErrW-1:0]  err, dm, ds, e_s, dm_s, ds_s;

    always_comb
    begin
        tick_inc = (tick_count_reg != {DataW{1'b1}}) ? tick_count_reg + 1'b1 : tick_count_reg;
        init     = cfg.auto_mode && !was_auto_reg;
        fire     = cfg.auto_mode && (tick_inc >= cfg.sample_period);

        // Entering auto takes the current samples as the previous ones.
        prev_m = init ? item.measurement : prev_meas_reg;
        prev_s = init ? item.setpoint : prev_sp_reg;

        err = {item.setpoint[DataW-1], item.setpoint}
              - {item.measurement[DataW-1], item.measurement};
        dm  = {item.measurement[DataW-1], item.measurement} - {prev_m[DataW-1], prev_m};
        ds  = {item.setpoint[DataW-1], item.setpoint} - {prev_s[DataW-1], prev_s};

        e_s  = cfg.reverse_direction ? -err : err;
        dm_s = cfg.reverse_direction ? -dm : dm;
        ds_s = cfg.reverse_direction ? -ds : ds;

        if (item.manual_output > cfg.out_max)
        begin
            cm = cfg.out_max;
        end
        else if (item.manual_output < cfg.out_min)
        begin
            cm = cfg.out_min;
        end
        else
        begin
            cm = item.manual_output;
        end

        a_data_next.init     = init;
        a_data_next.fire     = fire;
        a_data_next.init_val = clamp_integral({{(IntSumW-DataW-16){cm[DataW-1]}}, cm, 16'b0},
                                              cfg.out_min, cfg.out_max);
        a_data_next.p_kp  = ProdW'($signed({1'b0, cfg.kp_gain}) * e_s);
        a_data_next.p_ki  = ProdW'($signed({1'b0, cfg.ki_gain}) * e_s);
        a_data_next.p_kdm = ProdW'($signed({1'b0, cfg.kd_gain}) * dm_s);
        a_data_next.p_kds = ProdW'($signed({1'b0, cfg.kd_gain}) * ds_s);

        a_valid_next = in_valid && (init || fire);

        tick_count_next = tick_count_reg;
        was_auto_next   = was_auto_reg;
        prev_meas_next  = prev_meas_reg;
        prev_sp_next    = prev_sp_reg;
        if (in_valid)
        begin
            tick_count_next = fire ? '0 : tick_inc;
            was_auto_next   = cfg.auto_mode;
            if (init || fire)
            begin
                prev_meas_next = item.measurement;
                prev_sp_next   = item.setpoint;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tick_count_reg <= {DataW{1'b1}};
            was_auto_reg   <= 1'b0;
            prev_meas_reg  <= '0;
            prev_sp_reg    <= '0;
            a_valid_reg    <= 1'b0;
        end
        else
        begin
            tick_count_reg <= tick_count_next;
            was_auto_reg   <= was_auto_next;
            prev_meas_reg  <= prev_meas_next;
            prev_sp_reg    <= prev_sp_next;
            a_valid_reg    <= a_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        a_data_reg <= a_data_next;
    end

    assign a_valid = a_valid_reg;
    assign a_data  = a_data_reg;

endmodule

// File: src/pidc_integ.sv
`timescale 1ns / 1ps

module pidc_integ (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              a_valid,
    input  pidc_pkg::front_t  a_data,
    input  pidc_pkg::cfg_t    cfg,
    output logic              b_valid,
    output pidc_pkg::mid_t    b_data
);
    import pidc_pkg::*;

    logic signed [IntW-1:0]    integral_reg, integral_next;
    logic                      b_valid_reg, b_valid_next;
    mid_t                      b_data_reg, b_data_next;
    logic signed [IntW-1:0]    base;
    logic signed [IntSumW-1:0] sum;
    logic signed [IntW-1:0]    i_new;

    always_comb
    begin
        // The integral recurrence closes inside this stage.
        base  = a_data.init ? a_data.init_val : integral_reg;
        sum   = {{(IntSumW-IntW){base[IntW-1]}}, base}
                + {a_data.p_ki[ProdW-1], a_data.p_ki};
        i_new = clamp_integral(sum, cfg.out_min, cfg.out_max);

        integral_next = integral_reg;
        if (a_valid)
        begin
            integral_next = a_data.fire ? i_new : base;
        end

        b_valid_next      = a_valid && a_data.fire;
        b_data_next.i_new = i_new;
        b_data_next.pd    = {a_data.p_kp[ProdW-1], a_data.p_kp}
                            - {a_data.p_kdm[ProdW-1], a_data.p_kdm};
        b_data_next.p_kds = a_data.p_kds;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            integral_reg <= '0;
            b_valid_reg  <= 1'b0;
        end
        else
        begin
            integral_reg <= integral_next;
            b_valid_reg  <= b_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        b_data_reg <= b_data_next;
    end

    assign b_valid = b_valid_reg;
    assign b_data  = b_data_reg;

endmodule

// File: src/pidc_output.sv
`timescale 1ns / 1ps

module pidc_output (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            b_valid,
    input  pidc_pkg::mid_t                  b_data,
    input  pidc_pkg::cfg_t                  cfg,
    output logic [3:0]                      busy,
    output logic                            r_valid,
    output logic signed [pidc_pkg::DataW-1:0] r_drive
);
    import pidc_pkg::*;

    logic                     c_valid_reg, d_valid_reg, e_valid_reg, r_valid_reg;
    logic signed [AccW-1:0]   c_acc_reg, c_acc_next;
    logic signed [ProdW-1:0]  c_kds_reg;
    logic signed [YW-1:0]     d_y_reg, d_y_next;
    logic                     e_gt_reg, e_gt_next, e_lt_reg, e_lt_next;
    logic [MulW-1:0]          e_prod_reg, e_prod_next;
    logic signed [DataW-1:0]  r_drive_reg, r_drive_next;

    logic signed [TW-1:0]     a_ext, t;
    logic signed [ErrW-1:0]   hi1;
    logic signed [LimW-1:0]   h25, l25, lim_hi, lim_lo;
    logic [ZW-1:0]            zb;
    logic [DataW-1:0]         qp, q;

    always_comb
    begin
        c_acc_next = {b_data.pd[PdW-1], b_data.pd}
                     + {{(AccW-IntW){b_data.i_new[IntW-1]}}, b_data.i_new};

        // 200 * acc + kd*dS + rounding bias, then drop the 16 fraction bits.
        a_ext    = {{(TW-AccW){c_acc_reg[AccW-1]}}, c_acc_reg};
        t        = (a_ext <<< 7) + (a_ext <<< 6) + (a_ext <<< 3)
                   + {{(TW-ProdW){c_kds_reg[ProdW-1]}}, c_kds_reg} + RoundBias;
        d_y_next = t[TW-1:16];

        // drive > max exactly when y >= 200*(max+1); drive < min when y < 200*min.
        hi1    = {cfg.out_max[DataW-1], cfg.out_max} + 17'sd1;
        h25    = {{(LimW-ErrW){hi1[ErrW-1]}}, hi1};
        l25    = {{(LimW-DataW){cfg.out_min[DataW-1]}}, cfg.out_min};
        lim_hi = (h25 <<< 7) + (h25 <<< 6) + (h25 <<< 3);
        lim_lo = (l25 <<< 7) + (l25 <<< 6) + (l25 <<< 3);
        e_gt_next = d_y_reg >= $signed({{(YW-LimW){lim_hi[LimW-1]}}, lim_hi});
        e_lt_next = d_y_reg < $signed({{(YW-LimW){lim_lo[LimW-1]}}, lim_lo});

        // In range y fits 24 bits; y/200 = (y/8)/25 via a reciprocal multiply.
        zb          = d_y_reg[ZW+2:3] + ZBias;
        e_prod_next = {{(MulW-ZW){1'b0}}, zb} * {{(MulW-RecipW){1'b0}}, RecipMul};

        qp = e_prod_reg[RecipShift+DataW-1:RecipShift];
        q  = qp - 16'h8000;
        if (e_gt_reg)
        begin
            r_drive_next = cfg.out_max;
        end
        else if (e_lt_reg)
        begin
            r_drive_next = cfg.out_min;
        end
        else
        begin
            r_drive_next = $signed(q);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            c_valid_reg <= 1'b0;
            d_valid_reg <= 1'b0;
            e_valid_reg <= 1'b0;
            r_valid_reg <= 1'b0;
        end
        else
        begin
            c_valid_reg <= b_valid;
            d_valid_reg <= c_valid_reg;
            e_valid_reg <= d_valid_reg;
            r_valid_reg <= e_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        c_acc_reg   <= c_acc_next;
        c_kds_reg   <= b_data.p_kds;
        d_y_reg     <= d_y_next;
        e_gt_reg    <= e_gt_next;
        e_lt_reg    <= e_lt_next;
        e_prod_reg  <= e_prod_next;
        r_drive_reg <= r_drive_next;
    end

    assign busy    = {r_valid_reg, e_valid_reg, d_valid_reg, c_valid_reg};
    assign r_valid = r_valid_reg;
    assign r_drive = r_drive_reg;

endmodule

// File: src/pidc_fifo.sv
`timescale 1ns / 1ps

module pidc_fifo (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        push,
    input  logic [pidc_pkg::DataW-1:0]  push_data,
    input  logic                        pop,
    output logic                        not_empty,
    output logic [pidc_pkg::DataW-1:0]  head,
    output logic [pidc_pkg::QCntW-1:0]  count
);
    import pidc_pkg::*;

    logic [DataW-1:0] q_mem [QDepth];
    logic [QPtrW-1:0] wr_ptr_reg, wr_ptr_next;
    logic [QPtrW-1:0] rd_ptr_reg, rd_ptr_next;
    logic [QCntW-1:0] count_reg, count_next;

    always_comb
    begin
        wr_ptr_next = push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = pop ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        count_next  = count_reg + {{(QCntW-1){1'b0}}, push} - {{(QCntW-1){1'b0}}, pop};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            q_mem[wr_ptr_reg] <= push_data;
        end
    end

    assign not_empty = (count_reg != '0);
    assign head      = q_mem[rd_ptr_reg];
    assign count     = count_reg;

endmodule
